// ===== rtl/core/sfr_pkg.sv =====
// Shared types and constants for the streaming find-and-replace core.
// No dependencies.
package sfr_pkg;

    localparam int REC_BYTES   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int CASE_GAP    = 32;

    typedef enum logic [2:0] {
        CFG_PATTERN_BYTES      = 3'd0,
        CFG_PATTERN_LENGTH     = 3'd1,
        CFG_REPLACEMENT_BYTES  = 3'd2,
        CFG_REPLACEMENT_LENGTH = 3'd3,
        CFG_CASE_EXACT         = 3'd4
    } t_cfg_idx;

    // One record per accepted byte as the back end sees it: the first ncopy
    // window bytes, then the replacement when hit is set.
    typedef struct packed {
        logic [REC_BYTES-1:0][7:0] win;
        logic [3:0]                ncopy;
        logic                      hit;
        logic                      last;
        logic [15:0]               count;
    } t_rec;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic same_byte(input logic [7:0] c, input logic [7:0] d,
                                       input logic exact);
        logic eq;
        eq = (c == d);
        if (!eq && !exact && is_letter(c) && is_letter(d)) begin
            eq = (c == d + 8'(CASE_GAP)) || (d == c + 8'(CASE_GAP));
        end
        return eq;
    endfunction

endpackage

// ===== rtl/core/sfr_front.sv =====
// Front end: holds the match window, classifies each accepted byte and
// builds one queue record per accepted byte. Depends on sfr_pkg.
module sfr_front #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_text_byte,
    input  logic          i_text_end,
    input  logic          i_clear_fill,
    input  logic [63:0]   i_pattern_bytes,
    input  logic [3:0]    i_pattern_length,
    input  logic          i_case_exact,
    output sfr_pkg::t_rec o_rec
);
    import sfr_pkg::*;

    localparam int FW = $clog2(MAX_PATTERN + 1);

    logic [7:0]            r_win [MAX_PATTERN];
    logic [FW-1:0]         r_fill;
    logic [COUNT_BITS-1:0] r_total;

    logic [7:0]            ext   [MAX_PATTERN];
    logic [7:0]            n_win [MAX_PATTERN];
    logic [MAX_PATTERN:0]  ok;
    logic [FW-1:0]         eplen;
    logic [FW-1:0]         k;
    logic [FW-1:0]         rem;
    logic                  hit;
    logic [FW-1:0]         n_fill;
    logic [COUNT_BITS-1:0] n_total;
    logic [COUNT_BITS-1:0] tot_inc;

    always_comb begin
        if (i_pattern_length == 4'd0) begin
            eplen = FW'(1);
        end else if (i_pattern_length > 4'(MAX_PATTERN)) begin
            eplen = FW'(MAX_PATTERN);
        end else begin
            eplen = FW'(i_pattern_length);
        end

        for (int i = 0; i < MAX_PATTERN; i++) begin
            ext[i] = (i == int'(r_fill)) ? i_text_byte : r_win[i];
        end

        // ok[s]: window with the first s bytes dropped is a pattern prefix
        for (int s = 0; s <= MAX_PATTERN; s++) begin
            ok[s] = 1'b1;
            for (int j = 0; j < MAX_PATTERN - s; j++) begin
                if (s + j <= int'(r_fill)) begin
                    if (!same_byte(ext[s+j], i_pattern_bytes[8*j +: 8], i_case_exact)) begin
                        ok[s] = 1'b0;
                    end
                end
            end
        end

        k = FW'(MAX_PATTERN);
        for (int s = MAX_PATTERN; s >= 0; s--) begin
            if (ok[s]) begin
                k = FW'(s);
            end
        end

        rem = r_fill + FW'(1) - k;
        hit = (rem == eplen);

        for (int i = 0; i < MAX_PATTERN; i++) begin
            n_win[i] = ext[i];
            for (int s = 1; s < MAX_PATTERN - i; s++) begin
                if (FW'(s) == k) begin
                    n_win[i] = ext[i+s];
                end
            end
        end

        n_fill  = (hit || i_text_end) ? '0 : rem;
        tot_inc = (hit && r_total != '1) ? r_total + COUNT_BITS'(1) : r_total;
        n_total = i_text_end ? '0 : tot_inc;

        o_rec.win = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            o_rec.win[i] = ext[i];
        end
        o_rec.ncopy = (i_text_end && !hit) ? 4'(r_fill + FW'(1)) : 4'(k);
        o_rec.hit   = hit;
        o_rec.last  = i_text_end;
        if (!i_text_end) begin
            o_rec.count = '0;
        end else if (COUNT_BITS > 16 && (tot_inc >> 16) != '0) begin
            o_rec.count = '1;
        end else begin
            o_rec.count = 16'(tot_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_total <= '0;
        end else if (i_clear_fill) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== rtl/core/sfr_queue.sv =====
// Short record queue between front and back ends.
// Depends on sfr_pkg.
module sfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  sfr_pkg::t_rec i_data,
    input  logic          i_rd,
    output sfr_pkg::t_rec o_data,
    output logic          o_full,
    output logic          o_empty
);
    import sfr_pkg::*;

    t_rec                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wp;
    logic [QPTR_BITS-1:0] r_rp;
    logic [QPTR_BITS:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + QPTR_BITS'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + QPTR_BITS'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + (QPTR_BITS+1)'(1);
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - (QPTR_BITS+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/sfr_back.sv =====
// Back end: walks the head record into the output register, one word
// per cycle while it is free or being popped. Depends on sfr_pkg.
module sfr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfr_pkg::t_rec i_rec,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  logic [63:0]   i_replacement_bytes,
    input  logic [3:0]    i_replacement_length,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_valid,
    output logic          o_text_done,
    output logic [15:0]   o_replace_count
);
    import sfr_pkg::*;

    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic        r_bvalid;
    logic        r_done;
    logic [15:0] r_count;

    logic [3:0]  rl;
    logic [4:0]  tot;
    logic [4:0]  nres;
    logic        out_free;
    logic        step;
    logic        final_word;
    logic [2:0]  rsel;
    logic [7:0]  sel_byte;

    always_comb begin
        rl         = (i_replacement_length > 4'd8) ? 4'd8 : i_replacement_length;
        tot        = 5'(i_rec.ncopy) + (i_rec.hit ? 5'(rl) : 5'd0);
        nres       = (tot == 5'd0 && i_rec.last) ? 5'd1 : tot;
        out_free   = !r_out_valid || i_pop;
        step       = !i_q_empty && (nres == 5'd0 || out_free);
        final_word = (nres == 5'd0) || ({1'b0, r_idx} == nres - 5'd1);
        o_q_pop    = step && final_word;
        rsel       = 3'(r_idx - i_rec.ncopy);
        if (tot == 5'd0) begin
            sel_byte = 8'd0;
        end else if (r_idx < i_rec.ncopy) begin
            sel_byte = i_rec.win[r_idx[2:0]];
        end else begin
            sel_byte = i_replacement_bytes[{rsel, 3'b000} +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_idx <= final_word ? 4'd0 : r_idx + 4'd1;
            end
            if (out_free) begin
                r_out_valid <= step && (nres != 5'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && nres != 5'd0) begin
            r_byte   <= sel_byte;
            r_bvalid <= (tot != 5'd0);
            r_done   <= i_rec.last && final_word;
            r_count  <= (i_rec.last && final_word) ? i_rec.count : 16'd0;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bvalid;
    assign o_text_done     = r_done;
    assign o_replace_count = r_count;

endmodule

// ===== rtl/core/stream_find_replace_core.sv =====
// Channel   | handshake        | payload
// text in   | push / full      | i_text_byte, i_text_end
// text out  | empty / pop      | o_out_byte, o_byte_valid, o_text_done, o_replace_count
// config    | i_cfg_we         | i_cfg_idx, i_cfg_data
//
// One input byte per cycle while full is low; each byte becomes a record in a
// 4-deep queue. The back end emits one output word per cycle while its output
// register is free or popped, so expanding bytes (replacement, flush) fill the queue.
// Reset (synchronous, active low) empties window, queue and output register.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
module stream_find_replace_core #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_text_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_text_done,
    output logic [15:0] o_replace_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import sfr_pkg::*;

    logic [63:0] r_pattern_bytes;
    logic [3:0]  r_pattern_length;
    logic [63:0] r_replacement_bytes;
    logic [3:0]  r_replacement_length;
    logic        r_case_exact;

    t_rec rec_in;
    t_rec rec_head;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;
    logic clear_fill;

    assign full       = q_full;
    assign accept     = push && !q_full;
    assign clear_fill = i_cfg_we && (i_cfg_idx == CFG_PATTERN_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes      <= '0;
            r_pattern_length     <= 4'd1;
            r_replacement_bytes  <= '0;
            r_replacement_length <= '0;
            r_case_exact         <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_BYTES:      r_pattern_bytes      <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_pattern_length     <= i_cfg_data[3:0];
                CFG_REPLACEMENT_BYTES:  r_replacement_bytes  <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_replacement_length <= i_cfg_data[3:0];
                CFG_CASE_EXACT:         r_case_exact         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_text_byte      (i_text_byte),
        .i_text_end       (i_text_end),
        .i_clear_fill     (clear_fill),
        .i_pattern_bytes  (r_pattern_bytes),
        .i_pattern_length (r_pattern_length),
        .i_case_exact     (r_case_exact),
        .o_rec            (rec_in)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_data  (rec_in),
        .i_rd    (q_pop),
        .o_data  (rec_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sfr_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_rec                (rec_head),
        .i_q_empty            (q_empty),
        .o_q_pop              (q_pop),
        .i_replacement_bytes  (r_replacement_bytes),
        .i_replacement_length (r_replacement_length),
        .i_pop                (pop),
        .o_empty              (empty),
        .o_out_byte           (o_out_byte),
        .o_byte_valid         (o_byte_valid),
        .o_text_done          (o_text_done),
        .o_replace_count      (o_replace_count)
    );

endmodule

// ===== rtl/core/sfr_checker.sv =====
// Port-level checks for stream_find_replace_core, bound to the top level.
// Depends on stream_find_replace_core.
module sfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_out_byte,
    input logic        o_byte_valid,
    input logic        o_text_done,
    input logic [15:0] o_replace_count
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_text_done))
        else $error("stalled output word changed");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_valid |-> o_text_done && o_out_byte == 8'd0)
        else $error("bare word without end of text");

    a_count_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_text_done |-> o_replace_count == 16'd0)
        else $error("count shown before end of text");

endmodule

bind stream_find_replace_core sfr_checker u_sfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_out_byte      (o_out_byte),
    .o_byte_valid    (o_byte_valid),
    .o_text_done     (o_text_done),
    .o_replace_count (o_replace_count)
);
